/* hw/rtl/cpad_pkg.sv */
// ----------------------------------------------------------------------------
// cpad_pkg: shared types and constants
// Word formats, sequencer states and fixed-point sizes for the crank peak
// angle detector.
// ----------------------------------------------------------------------------
package cpad_pkg;

  localparam int CodeBits     = 14;
  localparam int OffsetBits   = 24;
  localparam int MaxTies      = 16;
  localparam int TieIdxBits   = (MaxTies > 1) ? $clog2(MaxTies) : 1;
  localparam int TieCntBits   = $clog2(MaxTies + 1);
  localparam int FracBits     = 16;
  localparam int CountBits    = 24;
  localparam int SumBits      = 48;
  localparam int TotalBits    = OffsetBits + TieCntBits;
  localparam int ProdBits     = OffsetBits + 9;
  // Dividend wide enough for offset*360*2^F and for the rounded mean.
  localparam int DivBits      = (ProdBits + FracBits > SumBits + 1) ?
                                ProdBits + FracBits : SumBits + 1;
  localparam int DivCntBits   = $clog2(DivBits + 1);

  localparam logic [CodeBits-1:0]   MidScale     = 14'd8192;
  localparam logic [CodeBits-1:0]   ThreshReset  = 14'd12288;
  localparam logic [8:0]            FullTurn     = 9'd360;
  localparam logic [OffsetBits-1:0] OffsetMax    = {OffsetBits{1'b1}};
  localparam logic [CountBits-1:0]  CountMax     = {CountBits{1'b1}};
  localparam logic [SumBits-1:0]    SumMax       = {SumBits{1'b1}};

  typedef struct packed {
    logic [CodeBits-1:0] marker_sample;
    logic [CodeBits-1:0] signal_sample;
    logic                last_sample;
  } in_word_t;

  typedef struct packed {
    logic [8:0]           angle_deg;
    logic [CountBits-1:0] revolutions_used;
    logic                 result_valid;
    logic                 tie_overflow;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM,
    ST_MEAN,
    ST_MEAN_WAIT,
    ST_PICK,
    ST_ANGLE,
    ST_ANGLE_WAIT,
    ST_ACCUM,
    ST_FINAL,
    ST_FINAL_WAIT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic                start;
    logic [DivBits-1:0]  dividend;
    logic [SumBits+FracBits-1:0] divisor;
  } div_req_t;

endpackage

/* hw/rtl/cpad_div.sv */
// ----------------------------------------------------------------------------
// cpad_div: shared restoring divider
// One quotient bit per cycle; quotient held until next start.
// ----------------------------------------------------------------------------
module cpad_div
  import cpad_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  div_req_t             req,
  output logic                 busy,
  output logic [DivBits-1:0]   quotient
);

  logic [DivCntBits-1:0]         count;
  logic [SumBits+FracBits-1:0]   divisor;
  logic [SumBits+FracBits-1:0]   remainder;
  logic [SumBits+FracBits:0]     trial;

  // Shift in the next dividend bit and try the subtract
  assign trial = {remainder, quotient[DivBits-1]} - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (req.start) begin
      busy      <= 1'b1;
      count     <= DivCntBits'(DivBits);
      quotient  <= req.dividend;
      remainder <= '0;
      divisor   <= req.divisor;
    end else if (busy) begin
      if (trial[SumBits+FracBits]) begin
        remainder <= {remainder[SumBits+FracBits-2:0], quotient[DivBits-1]};
        quotient  <= {quotient[DivBits-2:0], 1'b0};
      end else begin
        remainder <= trial[SumBits+FracBits-1:0];
        quotient  <= {quotient[DivBits-2:0], 1'b1};
      end
      count <= count - 1'b1;
      if (count == DivCntBits'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) req.start |=> busy)
    else $error("divider did not start");
  assert property (@(posedge clk) disable iff (rst)
    busy && count == DivCntBits'(1) && !req.start |=> !busy)
    else $error("divider overran its bit count");
  assert property (@(posedge clk) disable iff (rst) !busy |-> count == '0 || req.start)
    else $error("idle divider holds a count");

endmodule

/* hw/rtl/crank_peak_angle_detector_top.sv */
// ----------------------------------------------------------------------------
// crank_peak_angle_detector_top: revolution peak angle averager
// Tracks the signal maximum per revolution and emits the rounded mean angle
// of the peak after the revolution mark on the last sample.
//
//   channel   signals                         direction
//   in        in_valid / in_ready / in_data   word in
//   out       out_valid / out_ready / out_data word out
//   cfg       cfg_we / cfg_data               threshold write
//
// An ordinary sample is accepted in ST_IDLE, then passes ST_SUM back to idle.
// A revolution close sums the ties, divides for their mean, picks the tie
// nearest the mean (the first of equally near ties) and divides for the angle.
// The last sample adds the final mean divide, skipped with no revolution.
// Reset (rst, synchronous) clears all control state; the threshold returns
// to 12288. A finished word waits in the output register while new samples
// are taken; a second result holds the sequencer until the first is taken.
// ----------------------------------------------------------------------------
module crank_peak_angle_detector_top
  import cpad_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_word_t            in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output out_word_t           out_data,
  input  logic                cfg_we,
  input  logic [CodeBits-1:0] cfg_data
);

  state_t state, state_next;

  logic [CodeBits-1:0]   marker_threshold;
  logic                  mark_armed_off;
  logic [1:0]            marks_seen;
  logic [OffsetBits-1:0] segment_offset;
  logic [CodeBits-1:0]   segment_max;
  logic [OffsetBits-1:0] tie_positions [MaxTies];
  logic [TieCntBits-1:0] tie_count;
  logic [SumBits-1:0]    angle_sum;
  logic [CountBits-1:0]  revolution_count;
  logic                  overflow_flag;

  // Latched sample and close context
  logic                  last_pend;
  logic                  close_pend;
  logic [OffsetBits-1:0] period;
  logic [TieIdxBits-1:0] walk_idx;
  logic [TotalBits-1:0]  total;
  logic [OffsetBits-1:0] mean;
  logic [OffsetBits-1:0] best;
  logic [OffsetBits-1:0] best_diff;
  logic [DivBits-1:0]    whole;
  logic [CodeBits-1:0]   sig_hold;

  div_req_t                    dreq;
  logic                        dbusy;
  logic [DivBits-1:0]          dq;

  cpad_div u_div (
    .clk       (clk),
    .rst       (rst),
    .req       (dreq),
    .busy      (dbusy),
    .quotient  (dq)
  );

  // Sample bookkeeping done in the accept cycle
  logic                  is_mark;
  logic                  armed_next;
  logic [OffsetBits-1:0] off_inc;
  logic [CodeBits-1:0]   sig;
  logic [OffsetBits-1:0] walk_pos;
  logic [OffsetBits-1:0] walk_diff;
  logic [SumBits:0]      sum_add;
  logic                  emit_go;

  assign in_ready = (state == ST_IDLE);
  assign emit_go  = !out_valid || out_ready;
  assign sig      = in_data.signal_sample;
  assign is_mark  = (in_data.marker_sample > marker_threshold) && !mark_armed_off;
  assign armed_next = (is_mark || mark_armed_off) &&
                      !(in_data.marker_sample < MidScale);
  assign off_inc  = (segment_offset < OffsetMax) ? segment_offset + 1'b1 : segment_offset;
  assign walk_pos = tie_positions[walk_idx];
  assign walk_diff = (walk_pos > mean) ? walk_pos - mean : mean - walk_pos;
  assign sum_add  = {1'b0, angle_sum} +
                    (SumBits+1)'({whole[ProdBits-1:0], dq[FracBits-1:0]});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequence the close and the final mean
  always_comb begin
    state_next    = state;
    dreq.start    = 1'b0;
    dreq.dividend = '0;
    dreq.divisor  = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          state_next = ST_SUM;
        end
      end
      ST_SUM: begin
        if (!close_pend) begin
          state_next = last_pend ? ST_FINAL : ST_IDLE;
        end else if (32'(walk_idx) + 1 >= 32'(tie_count)) begin
          state_next = ST_MEAN;
        end
      end
      ST_MEAN: begin
        dreq.start    = 1'b1;
        dreq.dividend = DivBits'(total);
        dreq.divisor  = (SumBits+FracBits)'(tie_count);
        state_next    = ST_MEAN_WAIT;
      end
      ST_MEAN_WAIT: begin
        if (!dbusy) begin
          state_next = ST_PICK;
        end
      end
      ST_PICK: begin
        if (32'(walk_idx) + 1 >= 32'(tie_count)) begin
          state_next = ST_ANGLE;
        end
      end
      ST_ANGLE: begin
        dreq.start    = 1'b1;
        dreq.dividend = DivBits'({ProdBits'(best) * ProdBits'(FullTurn), {FracBits{1'b0}}});
        dreq.divisor  = (SumBits+FracBits)'(period);
        state_next    = ST_ANGLE_WAIT;
      end
      ST_ANGLE_WAIT: begin
        if (!dbusy) begin
          state_next = ST_ACCUM;
        end
      end
      ST_ACCUM: begin
        state_next = last_pend ? ST_FINAL : ST_IDLE;
      end
      ST_FINAL: begin
        if (revolution_count == '0) begin
          state_next = ST_EMIT;
        end else begin
          dreq.start    = 1'b1;
          dreq.dividend = DivBits'(angle_sum) +
                          DivBits'({revolution_count, {(FracBits-1){1'b0}}});
          dreq.divisor  = (SumBits+FracBits)'({revolution_count, {FracBits{1'b0}}});
          state_next    = ST_FINAL_WAIT;
        end
      end
      ST_FINAL_WAIT: begin
        if (!dbusy) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      marker_threshold <= ThreshReset;
    end else if (cfg_we) begin
      marker_threshold <= cfg_data;
    end
  end

  // Tie store: written on accepted words; first slot cleared when a close is accumulated
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      if (is_mark && marks_seen != 2'd0 && !(marks_seen == 2'd2)) begin
        tie_positions[0] <= '0;
      end else if (marks_seen == 2'd2) begin
        if (is_mark) begin
          // closing sample tracked before the new segment opens
          if (sig > segment_max) begin
            tie_positions[0] <= off_inc;
          end else if (sig == segment_max && 32'(tie_count) < MaxTies) begin
            tie_positions[TieIdxBits'(tie_count)] <= off_inc;
          end
        end else if (sig > segment_max) begin
          tie_positions[0] <= off_inc;
        end else if (sig == segment_max && 32'(tie_count) < MaxTies) begin
          tie_positions[TieIdxBits'(tie_count)] <= off_inc;
        end
      end
    end else if (state == ST_ACCUM || (state == ST_SUM && !close_pend)) begin
      if (close_pend) begin
        tie_positions[0] <= '0;
      end
    end
  end

  // Sample tracking, close arithmetic and output word
  always_ff @(posedge clk) begin
    if (rst) begin
      mark_armed_off   <= 1'b0;
      marks_seen       <= 2'd0;
      segment_offset   <= '0;
      segment_max      <= '0;
      tie_count        <= '0;
      angle_sum        <= '0;
      revolution_count <= '0;
      overflow_flag    <= 1'b0;
      out_valid        <= 1'b0;
      last_pend        <= 1'b0;
      close_pend       <= 1'b0;
      walk_idx         <= '0;
    end else begin
      // Load the output word, or drop it once taken
      if (state == ST_EMIT && emit_go) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            mark_armed_off <= armed_next;
            last_pend      <= in_data.last_sample;
            close_pend     <= 1'b0;
            walk_idx       <= '0;
            total          <= '0;
            if (marks_seen == 2'd2) begin
              segment_offset <= off_inc;
              if (sig > segment_max) begin
                segment_max <= sig;
                tie_count   <= TieCntBits'(1);
              end else if (sig == segment_max) begin
                if (32'(tie_count) < MaxTies) begin
                  tie_count <= tie_count + 1'b1;
                end else begin
                  overflow_flag <= 1'b1;
                end
              end
              period     <= off_inc;
              close_pend <= is_mark && off_inc != '0;
            end
            if (is_mark) begin
              if (marks_seen == 2'd0) begin
                marks_seen <= 2'd1;
              end else begin
                marks_seen <= 2'd2;
                // at the second mark the segment opens here; later ones open after the close has been walked
                if (marks_seen == 2'd1) begin
                  segment_offset <= '0;
                  segment_max    <= sig;
                  tie_count      <= TieCntBits'(1);
                end
              end
            end
          end
        end
        ST_SUM: begin
          if (close_pend) begin
            total    <= total + TotalBits'(walk_pos);
            walk_idx <= walk_idx + 1'b1;
          end
        end
        ST_MEAN_WAIT: begin
          if (!dbusy) begin
            mean      <= dq[OffsetBits-1:0];
            best      <= tie_positions[0];
            best_diff <= dq[OffsetBits-1:0] - tie_positions[0];
            walk_idx  <= TieIdxBits'(1 % MaxTies);
          end
        end
        ST_PICK: begin
          if (32'(walk_idx) < 32'(tie_count) && walk_idx != '0 && walk_diff < best_diff) begin
            best_diff <= walk_diff;
            best      <= walk_pos;
          end
          walk_idx <= walk_idx + 1'b1;
        end
        ST_ANGLE_WAIT: begin
          if (!dbusy) begin
            whole <= dq >> FracBits;
          end
        end
        ST_ACCUM: begin
          // angle = whole.frac, where frac is the low FracBits of the held angle quotient
          if (revolution_count < CountMax) begin
            angle_sum        <= sum_add[SumBits] ? SumMax : sum_add[SumBits-1:0];
            revolution_count <= revolution_count + 1'b1;
          end
          segment_offset <= '0;
          segment_max    <= sig_hold;
          tie_count      <= TieCntBits'(1);
          close_pend     <= 1'b0;
        end
        ST_EMIT: begin
          if (emit_go) begin
            out_data.revolutions_used <= revolution_count;
            out_data.result_valid     <= revolution_count != '0;
            out_data.tie_overflow     <= overflow_flag;
            out_data.angle_deg        <= (revolution_count != '0) ? dq[8:0] : 9'd0;
            mark_armed_off            <= 1'b0;
            marks_seen                <= 2'd0;
            segment_offset            <= '0;
            segment_max               <= '0;
            tie_count                 <= '0;
            angle_sum                 <= '0;
            revolution_count          <= '0;
            overflow_flag             <= 1'b0;
            last_pend                 <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Keep the closing mark's signal to open the next segment
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sig_hold <= sig;
    end
  end

  assert property (@(posedge clk) disable iff (rst) out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");
  assert property (@(posedge clk) disable iff (rst) state != ST_IDLE |-> !in_ready)
    else $error("input taken while busy");
  assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT && emit_go |=> revolution_count == '0 && marks_seen == 2'd0)
    else $error("state not cleared after last sample");
  assert property (@(posedge clk) disable iff (rst) 32'(tie_count) <= MaxTies)
    else $error("tie count beyond storage");

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: crank peak angle detector testbench
// Drives acquisitions of marker and signal samples through the word handshake,
// predicts the mean peak angle per acquisition and checks every output word
// against it. Both sides idle at random; one long output hold-off fills
// the block.
// ----------------------------------------------------------------------------
module tb_top;
  import cpad_pkg::*;

  localparam int SettleCycles = 400;

  logic                clk = 1'b0;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  in_word_t            in_data;
  logic                out_valid;
  logic                out_ready;
  out_word_t           out_data;
  logic                cfg_we;
  logic [CodeBits-1:0] cfg_data;

  // predictor state
  logic [CodeBits-1:0]   threshold;
  bit                    armed_off;
  int unsigned           marks_seen;
  bit [OffsetBits-1:0]   seg_offset;
  bit [CodeBits-1:0]     seg_max;
  bit [OffsetBits-1:0]   tie_pos [MaxTies];
  int unsigned           tie_cnt;
  bit [63:0]             angle_sum;
  bit [CountBits-1:0]    rev_count;
  bit                    tie_ovf;

  out_word_t   expected_words[$];
  int unsigned mismatches;
  int unsigned words_sent;
  bit          calm;
  int unsigned hold_off_cycles;

  crank_peak_angle_detector_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always #2 clk = ~clk;

  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Clear the acquisition state but the threshold and the tie positions.
  function automatic void clear_acquisition();
    armed_off  = 1'b0;
    marks_seen = 0;
    seg_offset = '0;
    seg_max    = '0;
    tie_cnt    = 0;
    angle_sum  = '0;
    rev_count  = '0;
    tie_ovf    = 1'b0;
  endfunction

  // Close a revolution: pick the tie nearest the mean, scale to degrees, accumulate.
  function automatic void close_revolution();
    bit [63:0] total, mean, best, best_diff, d, prod, whole, rem, ang, period;
    period = seg_offset;
    if (period == 0 || tie_cnt == 0) return;
    total = 0;
    for (int i = 0; i < tie_cnt; i++) total += tie_pos[i];
    mean      = total / tie_cnt;
    best      = tie_pos[0];
    best_diff = mean - best;
    for (int i = 1; i < tie_cnt; i++) begin
      d = (tie_pos[i] > mean) ? tie_pos[i] - mean : mean - tie_pos[i];
      if (d < best_diff) begin
        best_diff = d;
        best      = tie_pos[i];
      end
    end
    prod  = best * 360;
    whole = prod / period;
    rem   = prod % period;
    ang   = (whole << FracBits) + ((rem << FracBits) / period);
    if (rev_count < CountMax) begin
      angle_sum += ang;
      if (angle_sum > SumMax) angle_sum = SumMax;
      rev_count++;
    end
  endfunction

  // Advance the predictor by one accepted word; queue a result on the last.
  function automatic void predict_peak_angle(in_word_t w);
    bit        is_mark;
    out_word_t r;
    bit [63:0] denom, half;
    is_mark = 1'b0;
    if (w.marker_sample > threshold && !armed_off) begin
      is_mark   = 1'b1;
      armed_off = 1'b1;
    end
    if (w.marker_sample < MidScale && armed_off) armed_off = 1'b0;
    if (marks_seen == 2) begin
      if (seg_offset < OffsetMax) seg_offset++;
      if (w.signal_sample > seg_max) begin
        seg_max    = w.signal_sample;
        tie_pos[0] = seg_offset;
        tie_cnt    = 1;
      end else if (w.signal_sample == seg_max) begin
        if (tie_cnt < MaxTies) begin
          tie_pos[tie_cnt] = seg_offset;
          tie_cnt++;
        end else begin
          tie_ovf = 1'b1;
        end
      end
      if (is_mark) close_revolution();
    end
    if (is_mark) begin
      if (marks_seen == 0) begin
        marks_seen = 1;
      end else begin
        marks_seen = 2;
        seg_offset = '0;
        seg_max    = w.signal_sample;
        tie_pos[0] = '0;
        tie_cnt    = 1;
      end
    end
    if (!w.last_sample) return;
    r = '0;
    if (rev_count > 0) begin
      denom              = 64'(rev_count) << FracBits;
      half               = 64'(rev_count) << (FracBits - 1);
      r.angle_deg        = 9'((angle_sum + half) / denom);
      r.revolutions_used = rev_count;
      r.result_valid     = 1'b1;
    end
    r.tie_overflow = tie_ovf;
    expected_words.insert(expected_words.size(), r);
    clear_acquisition();
  endfunction

  function automatic int unsigned draw_gap();
    if (calm) return 0;
    return $urandom_range(0, 17);
  endfunction

  function automatic logic [CodeBits-1:0] any_code();
    return CodeBits'($urandom_range(0, 14'h3FFF));
  endfunction

  // Offer one word and hold it until accepted.
  task automatic send_word(input logic [CodeBits-1:0] marker,
                           input logic [CodeBits-1:0] sig, input bit last);
    in_word_t    w;
    int unsigned gap;
    w.marker_sample = marker;
    w.signal_sample = sig;
    w.last_sample   = last;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    predict_peak_angle(w);
    words_sent++;
  endtask

  // Drop valid, wait for every expected word, then let the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [CodeBits-1:0] value);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    threshold  = value;
  endtask

  function automatic logic [CodeBits-1:0] high_marker();
    if (threshold == 14'h3FFF) return 14'h3FFF;
    return CodeBits'($urandom_range(threshold + 1, 14'h3FFF));
  endfunction

  // One acquisition of revolutions with random periods; peaks tie at times.
  task automatic send_acquisition(input int unsigned revs, input int unsigned max_period,
                                  input bit noisy);
    logic [CodeBits-1:0] peak, mk, sg;
    int unsigned         period;
    peak = any_code();
    for (int r = 0; r < revs; r++) begin
      period = $urandom_range(1, max_period);
      for (int s = 0; s < period; s++) begin
        if (noisy && $urandom_range(0, 9) == 0) mk = any_code();
        else if (s == 0) mk = high_marker();
        else mk = CodeBits'($urandom_range(0, MidScale - 1));
        sg = ($urandom_range(0, 3) == 0) ? peak : any_code();
        send_word(mk, sg, (r == revs - 1) && (s == period - 1));
      end
    end
  endtask

  // Default threshold, field extremes, no-revolution and single-word cases.
  task automatic test_extremes();
    send_word(14'h0000, 14'h0000, 1'b1);
    send_word(14'h3FFF, 14'h3FFF, 1'b0);
    send_word(14'h0000, 14'h0000, 1'b0);
    send_word(14'd12289, 14'h3FFF, 1'b0);
    send_word(14'd12288, 14'h0000, 1'b0);
    send_word(14'h0000, 14'd100, 1'b0);
    send_word(14'h3FFF, 14'h2AAA, 1'b0);
    send_word(14'd8192, 14'h1555, 1'b0);
    send_word(14'd8191, 14'h3FFF, 1'b0);
    send_word(14'h3FFF, 14'h0001, 1'b1);
  endtask

  // Flat signal: more tied maxima than the tie store holds.
  task automatic test_tie_overflow();
    for (int r = 0; r < 3; r++)
      for (int s = 0; s < 20; s++)
        send_word(s == 0 ? 14'h3FFF : 14'h0010, 14'd777, r == 2 && s == 19);
  endtask

  // Threshold below mid-scale: one word can mark and re-arm.
  task automatic test_low_threshold();
    write_threshold(14'd0);
    for (int i = 0; i < 6; i++) send_word(14'd1, any_code(), i == 5);
    write_threshold(14'd100);
    for (int i = 0; i < 6; i++) send_word(14'd200, 14'd50, i == 5);
  endtask

  // Top threshold: nothing can mark.
  task automatic test_high_threshold();
    write_threshold(14'h3FFF);
    send_acquisition(4, 5, 1'b0);
  endtask

  // Hold the output off while acquisitions keep coming.
  task automatic test_output_backpressure();
    write_threshold(ThreshReset);
    hold_off_cycles = 1500;
    for (int i = 0; i < 12; i++) send_acquisition(1, 2, 1'b0);
  endtask

  task automatic test_random_acquisitions();
    logic [CodeBits-1:0] thr;
    while (words_sent < 1350) begin
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 3))
          0:       thr = 14'd0;
          1:       thr = 14'h3FFE;
          default: thr = any_code();
        endcase
        write_threshold(thr);
      end
      calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) == 0) begin
        for (int i = $urandom_range(1, 30); i > 0; i--)
          send_word(any_code(), any_code(), i == 1);
      end else begin
        send_acquisition($urandom_range(1, 8), $urandom_range(1, 24), $urandom_range(0, 3) == 0);
      end
    end
    calm = 1'b0;
  endtask

  // Receiver: random stalls, calm stretches, and one long hold-off on request.
  initial begin
    int unsigned stall;
    out_ready <= 1'b0;
    @(negedge rst);
    forever begin
      if (hold_off_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_cycles = 0;
      end else begin
        stall = draw_gap();
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Compare each accepted result word with the oldest expectation.
  always @(posedge clk) begin
    out_word_t exp_w;
    if (!rst && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %p", out_data);
      end else begin
        exp_w = expected_words[0];
        expected_words.delete(0);
        if (out_data !== exp_w) begin
          mismatches++;
          if (mismatches <= 10) $display("result word: expected %p, actual %p", exp_w, out_data);
        end
      end
    end
  end

  initial begin
    rst             <= 1'b1;
    in_valid        <= 1'b0;
    in_data         <= '0;
    cfg_we          <= 1'b0;
    cfg_data        <= '0;
    mismatches      = 0;
    words_sent      = 0;
    calm            = 1'b0;
    hold_off_cycles = 0;
    threshold       = ThreshReset;
    clear_acquisition();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_extremes();
    test_tie_overflow();
    test_low_threshold();
    test_high_threshold();
    test_output_backpressure();
    test_random_acquisitions();
    drain();

    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

/* crank_peak_angle_detector_top.f */
hw/rtl/cpad_pkg.sv
hw/rtl/cpad_div.sv
hw/rtl/crank_peak_angle_detector_top.sv
bench/tb_top.sv
